// ===== rtl/twe_pkg.sv =====
// ----------------------------------------------------------------------------
// twe_pkg
// Shared types and constants of the timer wheel expiry core.
// ----------------------------------------------------------------------------
package twe_pkg;

    // Sizing of the wheel, the pool and the cpu table
    localparam int TIMER_ENTRIES_DEF = 32;
    localparam int WHEEL_SLOTS       = 64;
    localparam int SLOT_W            = $clog2(WHEEL_SLOTS);
    localparam int CPUS              = 8;
    localparam int CPU_W             = $clog2(CPUS);
    localparam int MAX_RESULTS       = 32;
    localparam int EMIT_W            = $clog2(MAX_RESULTS + 1);
    localparam int PEND_W            = 6;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 80;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    // Input item selector
    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Timer kinds
    localparam logic KIND_SLEEP    = 1'b0;
    localparam logic KIND_CALLBACK = 1'b1;

    // Result types
    localparam logic RES_ARM    = 1'b0;
    localparam logic RES_EXPIRY = 1'b1;

    // Arm status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_COUNT = 8'd1;

    // One stored timer
    typedef struct packed {
        logic        kind;
        logic [63:0] deadline;
        logic [15:0] owner;
        logic [15:0] context_tag;
        logic [31:0] id;
    } entry_t;

    // One result item
    typedef struct packed {
        logic              result_type;
        logic [1:0]        status;
        logic [31:0]       timer_id;
        logic              kind;
        logic [15:0]       owner;
        logic [15:0]       context_tag;
        logic              last;
        logic [PEND_W-1:0] pending;
    } result_t;

endpackage

// ===== rtl/twe_cmp.sv =====
// ----------------------------------------------------------------------------
// twe_cmp
// Shared 64-bit deadline compare unit: a <= b and wheel slot match.
// ----------------------------------------------------------------------------
module twe_cmp
    import twe_pkg::*;
(
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        le,
    output logic        slot_eq
);

    // Compare full deadline and wheel slot bits
    assign le      = (a <= b);
    assign slot_eq = (a[SLOT_W-1:0] == b[SLOT_W-1:0]);

endmodule

// ===== rtl/twe_store.sv =====
// ----------------------------------------------------------------------------
// twe_store
// Timer entry memory and arm-order ring, each one write and one registered read.
// ----------------------------------------------------------------------------
module twe_store
    import twe_pkg::*;
#(
    parameter int TIMER_ENTRIES = TIMER_ENTRIES_DEF,
    parameter int EW            = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1
)
(
    input  logic          clk,
    input  logic          ent_we,
    input  logic [EW-1:0] ent_waddr,
    input  entry_t        ent_wdata,
    input  logic [EW-1:0] ent_raddr,
    output entry_t        ent_rdata,
    input  logic          ord_we,
    input  logic [EW-1:0] ord_waddr,
    input  logic [EW-1:0] ord_wdata,
    input  logic [EW-1:0] ord_raddr,
    output logic [EW-1:0] ord_rdata
);

    entry_t        ent_mem [TIMER_ENTRIES];
    logic [EW-1:0] ord_mem [2**EW];

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata <= ent_mem[ent_raddr];
    end

    // Arm-order ring, oldest at head
    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata <= ord_mem[ord_raddr];
    end

endmodule

// ===== rtl/timer_wheel_expiry_core.sv =====
// Arm: checks the item, then a serial search for the lowest free entry, then writes
//   the entry and the ring tail.
// Tick: walks the arm-order ring through S_TK_ORD, S_TK_ENT and S_TK_CHK per armed
//   timer, using the shared deadline compare unit; one item in flight at a time.
// Reset clears the pool, counters and output; enabled = 1, cpu_count = 1.
// ----------------------------------------------------------------------------
// timer_wheel_expiry_core
// Hashed timing wheel over a fixed pool: arms timers and expires due entries
// newest-armed first on each tick.
// ----------------------------------------------------------------------------
module timer_wheel_expiry_core
    import twe_pkg::*;
#(
    parameter int TIMER_ENTRIES = TIMER_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // deadline[63:0] owner_id[79:64] context_tag[95:80] cpu[98:96] now_tick[162:99]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0] timer_kind[1]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0] timer_id[33:2] expired_kind[34] expired_owner[50:35]
    // expired_context[66:51] pending_timers[72:67]
    output logic [M_TDATA_W-1:0] m_tdata,
    // result_type[0]
    output logic [0:0]           m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int EW = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
    localparam int CW = EW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM_CHK,
        S_ARM_FIND,
        S_ARM_WR,
        S_RESP,
        S_TK_ORD,
        S_TK_ENT,
        S_TK_CHK
    } state_t;

    state_t state_reg;
    logic   tk_end_reg;

    // Configuration
    logic       enabled_reg;
    logic [3:0] cpu_count_reg;

    // Captured item
    logic        in_kind_reg;
    logic [63:0] in_deadline_reg;
    logic [15:0] in_owner_reg;
    logic [15:0] in_ctx_reg;

    // Block state
    logic [TIMER_ENTRIES-1:0] busy_reg;
    logic [CW-1:0]            busy_cnt_reg;
    logic [EW-1:0]            head_reg;
    logic [CW-1:0]            count_reg;
    logic [31:0]              next_id_reg;
    logic [63:0]              cur_time_reg;
    logic [63:0]              cpu_tick_count_reg [CPUS];
    logic [63:0]              cpu_last_tick_reg [CPUS];

    // Sequencer working registers
    logic [EW-1:0]     k_reg;
    logic [EW-1:0]     pos_reg;
    logic [EW-1:0]     wr_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     surv_reg;
    logic [EW-1:0]     idx_reg;
    logic [EMIT_W-1:0] emit_cnt_reg;
    logic              hold_vld_reg;
    result_t           hold_reg;
    result_t           resp_reg;
    logic              out_vld_reg;
    result_t           out_reg;

    // Store and compare connections
    logic          ent_we;
    entry_t        ent_wdata;
    logic [EW-1:0] ent_raddr;
    entry_t        ent_rdata;
    logic          ord_we;
    logic [EW-1:0] ord_waddr;
    logic [EW-1:0] ord_wdata;
    logic [EW-1:0] ord_rdata;
    logic [63:0]   cmp_a;
    logic          cmp_le;
    logic          cmp_slot_eq;

    logic          out_free;
    logic          due;
    logic          stall;
    logic [EW-1:0] tail_addr;
    logic [CW-1:0] busy_dec;
    logic [CW-1:0] busy_inc;
    logic [7:0]    pend_dec;
    logic [7:0]    pend_cur;
    logic [7:0]    pend_inc;

    twe_store #(
        .TIMER_ENTRIES (TIMER_ENTRIES),
        .EW            (EW)
    ) u_store (
        .clk       (clk),
        .ent_we    (ent_we),
        .ent_waddr (k_reg),
        .ent_wdata (ent_wdata),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata),
        .ord_we    (ord_we),
        .ord_waddr (ord_waddr),
        .ord_wdata (ord_wdata),
        .ord_raddr (pos_reg),
        .ord_rdata (ord_rdata)
    );

    twe_cmp u_cmp (
        .a       (cmp_a),
        .b       (cur_time_reg),
        .le      (cmp_le),
        .slot_eq (cmp_slot_eq)
    );

    // Handshake and derived values
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || m_tready;
    assign tail_addr = EW'(head_reg + count_reg[EW-1:0]);
    assign busy_dec  = busy_cnt_reg - CW'(1);
    assign busy_inc  = busy_cnt_reg + CW'(1);
    assign pend_cur  = 8'(busy_cnt_reg);
    assign pend_dec  = 8'(busy_dec);
    assign pend_inc  = 8'(busy_inc);
    assign cmp_a     = (state_reg == S_TK_CHK) ? ent_rdata.deadline : in_deadline_reg;
    assign due       = (state_reg == S_TK_CHK) && cmp_le && cmp_slot_eq &&
                       (emit_cnt_reg < EMIT_W'(MAX_RESULTS));
    assign stall     = due && hold_vld_reg && !out_free;

    // Store control
    always_comb
    begin
        ent_we                = (state_reg == S_ARM_WR);
        ent_wdata.kind        = in_kind_reg;
        ent_wdata.deadline    = in_deadline_reg;
        ent_wdata.owner       = in_owner_reg;
        ent_wdata.context_tag = (in_kind_reg == KIND_CALLBACK) ? in_ctx_reg : 16'd0;
        ent_wdata.id          = next_id_reg;
        ent_raddr             = ord_rdata;
        ord_we                = 1'b0;
        ord_waddr             = tail_addr;
        ord_wdata             = k_reg;
        if (state_reg == S_ARM_WR)
        begin
            ord_we = 1'b1;
        end
        else if (state_reg == S_TK_CHK && !due && !tk_end_reg)
        begin
            ord_we    = 1'b1;
            ord_waddr = wr_reg;
            ord_wdata = idx_reg;
        end
    end

    // Output port packing
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.result_type;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.pending, out_reg.context_tag, out_reg.owner,
                       out_reg.kind, out_reg.timer_id, out_reg.status};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            cpu_count_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLED:   enabled_reg <= cfg_data[0];
                CFG_CPU_COUNT:
                begin
                    if (cfg_data[3:0] == 4'd0)
                    begin
                        cpu_count_reg <= 4'd1;
                    end
                    else if (cfg_data[3:0] > 4'(CPUS))
                    begin
                        cpu_count_reg <= 4'(CPUS);
                    end
                    else
                    begin
                        cpu_count_reg <= cfg_data[3:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Captured item payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg     <= s_tuser[1];
            in_deadline_reg <= s_tdata[63:0];
            in_owner_reg    <= s_tdata[79:64];
            in_ctx_reg      <= s_tdata[95:80];
        end
        if (state_reg == S_TK_ENT)
        begin
            idx_reg <= ord_rdata;
        end
    end

    // Sequencer, pool state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tk_end_reg   <= 1'b0;
            busy_reg     <= '0;
            busy_cnt_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            next_id_reg  <= 32'd1;
            cur_time_reg <= '0;
            for (int c = 0; c < CPUS; c++)
            begin
                cpu_tick_count_reg[c] <= '0;
                cpu_last_tick_reg[c]  <= '0;
            end
            k_reg        <= '0;
            pos_reg      <= '0;
            wr_reg       <= '0;
            rem_reg      <= '0;
            surv_reg     <= '0;
            emit_cnt_reg <= '0;
            hold_vld_reg <= 1'b0;
            hold_reg     <= '0;
            resp_reg     <= '0;
            out_vld_reg  <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            // Drain the output register
            if (out_vld_reg && m_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser[0] == OP_ARM)
                        begin
                            state_reg <= S_ARM_CHK;
                        end
                        else if (enabled_reg)
                        begin
                            // Record time and the raising cpu's counter
                            cur_time_reg <= s_tdata[162:99];
                            if ({1'b0, s_tdata[98:96]} < cpu_count_reg)
                            begin
                                cpu_tick_count_reg[s_tdata[98:96]] <=
                                    cpu_tick_count_reg[s_tdata[98:96]] + 64'd1;
                                cpu_last_tick_reg[s_tdata[98:96]] <= s_tdata[162:99];
                            end
                            // Walk the ring newest first
                            pos_reg      <= EW'(tail_addr - EW'(1));
                            wr_reg       <= EW'(tail_addr - EW'(1));
                            rem_reg      <= count_reg;
                            surv_reg     <= '0;
                            emit_cnt_reg <= '0;
                            tk_end_reg   <= 1'b0;
                            if (count_reg != '0)
                            begin
                                state_reg <= S_TK_ORD;
                            end
                        end
                    end
                end

                S_ARM_CHK:
                begin
                    resp_reg             <= '0;
                    resp_reg.result_type <= RES_ARM;
                    resp_reg.last        <= 1'b1;
                    resp_reg.pending     <= pend_cur[PEND_W-1:0];
                    k_reg                <= '0;
                    if (!enabled_reg || cmp_le ||
                        (in_kind_reg == KIND_SLEEP && in_owner_reg == 16'd0))
                    begin
                        resp_reg.status <= ST_INVALID;
                        state_reg       <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_ARM_FIND;
                    end
                end

                S_ARM_FIND:
                begin
                    // Search for the lowest free entry one per cycle
                    if (!busy_reg[k_reg])
                    begin
                        state_reg <= S_ARM_WR;
                    end
                    else if (k_reg == EW'(TIMER_ENTRIES - 1))
                    begin
                        resp_reg.status <= ST_FULL;
                        state_reg       <= S_RESP;
                    end
                    else
                    begin
                        k_reg <= k_reg + EW'(1);
                    end
                end

                S_ARM_WR:
                begin
                    busy_reg[k_reg]   <= 1'b1;
                    busy_cnt_reg      <= busy_inc;
                    count_reg         <= count_reg + CW'(1);
                    next_id_reg       <= next_id_reg + 32'd1;
                    resp_reg.status   <= ST_ACCEPTED;
                    resp_reg.timer_id <= next_id_reg;
                    resp_reg.pending  <= pend_inc[PEND_W-1:0];
                    state_reg         <= S_RESP;
                end

                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        out_reg     <= resp_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                S_TK_ORD:
                begin
                    state_reg <= S_TK_ENT;
                end

                S_TK_ENT:
                begin
                    state_reg <= S_TK_CHK;
                end

                S_TK_CHK:
                begin
                    if (tk_end_reg)
                    begin
                        // Close the walk and flush the held expiry as last
                        head_reg  <= EW'(wr_reg + EW'(1));
                        count_reg <= surv_reg;
                        if (!hold_vld_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (out_free)
                        begin
                            out_vld_reg   <= 1'b1;
                            out_reg       <= hold_reg;
                            out_reg.last  <= 1'b1;
                            hold_vld_reg  <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else if (!stall)
                    begin
                        if (due)
                        begin
                            // Pass the previous expiry on and hold this one
                            if (hold_vld_reg)
                            begin
                                out_vld_reg <= 1'b1;
                                out_reg     <= hold_reg;
                            end
                            hold_vld_reg         <= 1'b1;
                            hold_reg.result_type <= RES_EXPIRY;
                            hold_reg.status      <= ST_ACCEPTED;
                            hold_reg.timer_id    <= ent_rdata.id;
                            hold_reg.kind        <= ent_rdata.kind;
                            hold_reg.owner       <= ent_rdata.owner;
                            hold_reg.context_tag <= ent_rdata.context_tag;
                            hold_reg.last        <= 1'b0;
                            hold_reg.pending     <= pend_dec[PEND_W-1:0];
                            busy_reg[idx_reg]    <= 1'b0;
                            busy_cnt_reg         <= busy_dec;
                            emit_cnt_reg         <= emit_cnt_reg + EMIT_W'(1);
                        end
                        else
                        begin
                            // Keep the survivor, packed toward the tail
                            wr_reg   <= wr_reg - EW'(1);
                            surv_reg <= surv_reg + CW'(1);
                        end
                        pos_reg <= pos_reg - EW'(1);
                        rem_reg <= rem_reg - CW'(1);
                        if (rem_reg == CW'(1))
                        begin
                            tk_end_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_TK_ORD;
                        end
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Ring and busy bits agree whenever the block is between items
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg == busy_cnt_reg))
        else $error("arm-order ring length differs from busy count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(busy_reg) == 32'(busy_cnt_reg)))
        else $error("busy count out of step with busy bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        hold_vld_reg |-> (state_reg == S_TK_ORD || state_reg == S_TK_ENT ||
                          state_reg == S_TK_CHK))
        else $error("held expiry outside a tick walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= EMIT_W'(MAX_RESULTS))
        else $error("too many expiries for one tick");

endmodule

// ===== tb/tb_timer_wheel_expiry_core.sv =====
// ----------------------------------------------------------------------------
// tb_timer_wheel_expiry_core
// Self-checking bench for the timer wheel core. A scoreboard predicts every
// arm response and expiry report from the accepted input transactions. Random
// sender gaps and receiver stalls run in phases, with one long receiver hold.
// ----------------------------------------------------------------------------
module tb_timer_wheel_expiry_core
    import twe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL       = TIMER_ENTRIES_DEF;
    localparam int TAIL_WAIT  = 3 * POOL + 40;
    localparam int STALL_LIMIT = 20000;

    // Scoreboard: timer pool predictor and queue of expected results
    class wheel_scoreboard;
        bit          enabled;
        logic [3:0]  cpu_count;
        bit          busy [POOL];
        logic        kind [POOL];
        logic [63:0] deadline [POOL];
        logic [15:0] owner [POOL];
        logic [15:0] ctx [POOL];
        logic [31:0] id [POOL];
        logic [31:0] stamp [POOL];
        logic [31:0] next_id;
        logic [31:0] arm_seq;
        logic [63:0] cur_time;
        logic [63:0] cpu_ticks [CPUS];
        result_t     pending_q [$];
        int          errors;

        function new();
            enabled   = 1;
            cpu_count = 4'd1;
            foreach (busy[i]) busy[i] = 0;
            foreach (cpu_ticks[i]) cpu_ticks[i] = 0;
            next_id  = 1;
            arm_seq  = 0;
            cur_time = 0;
            errors   = 0;
        endfunction

        function logic [PEND_W-1:0] armed_count();
            int n;
            n = 0;
            foreach (busy[i]) if (busy[i]) n++;
            return n[PEND_W-1:0];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            logic [3:0] v;
            v = val[3:0];
            if (idx == CFG_ENABLED)
                enabled = val[0];
            else if (idx == CFG_CPU_COUNT)
            begin
                if (v == 4'd0) v = 4'd1;
                if (v > 4'(CPUS)) v = 4'(CPUS);
                cpu_count = v;
            end
        endfunction

        // Predict the results of one accepted input transaction
        function void note_input(logic op, logic knd, logic [63:0] dl, logic [15:0] own,
                                 logic [15:0] cx, logic [2:0] cpu, logic [63:0] now);
            result_t r;
            int      slot;
            int      best;
            bit      due [POOL];
            int      ndue;
            r = '0;
            r.last = 1'b1;
            if (op == OP_ARM)
            begin
                r.result_type = RES_ARM;
                slot = -1;
                if (!enabled || dl <= cur_time || (knd == KIND_SLEEP && own == 0))
                    r.status = ST_INVALID;
                else
                begin
                    for (int i = POOL - 1; i >= 0; i--) if (!busy[i]) slot = i;
                    if (slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        busy[slot]     = 1;
                        kind[slot]     = knd;
                        deadline[slot] = dl;
                        owner[slot]    = own;
                        ctx[slot]      = (knd == KIND_CALLBACK) ? cx : 16'd0;
                        id[slot]       = next_id;
                        stamp[slot]    = arm_seq;
                        next_id++;
                        arm_seq++;
                        r.status   = ST_ACCEPTED;
                        r.timer_id = id[slot];
                    end
                end
                r.pending = armed_count();
                pending_q.push_back(r);
                return;
            end
            if (!enabled) return;
            cur_time = now;
            if (cpu < cpu_count) cpu_ticks[cpu]++;
            ndue = 0;
            foreach (busy[i])
            begin
                due[i] = busy[i] && deadline[i] <= now && deadline[i][5:0] == now[5:0];
                if (due[i]) ndue++;
            end
            // Emit newest-armed first, freeing each entry as it goes
            for (int n = 0; n < ndue && n < MAX_RESULTS; n++)
            begin
                best = -1;
                foreach (due[i])
                    if (due[i] && (best < 0 ||
                        (arm_seq - 32'd1 - stamp[i]) < (arm_seq - 32'd1 - stamp[best])))
                        best = i;
                due[best]  = 0;
                busy[best] = 0;
                r = '0;
                r.result_type = RES_EXPIRY;
                r.status      = ST_ACCEPTED;
                r.timer_id    = id[best];
                r.kind        = kind[best];
                r.owner       = owner[best];
                r.context_tag = ctx[best];
                r.last        = (n == ndue - 1) || (n == MAX_RESULTS - 1);
                r.pending     = armed_count();
                pending_q.push_back(r);
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check(result_t got);
            result_t w;
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected result id", 64'(got.timer_id), 64'd0);
                return;
            end
            w = pending_q.pop_front();
            if (got.result_type !== w.result_type)
                report_mismatch("result_type", 64'(got.result_type), 64'(w.result_type));
            if (got.status !== w.status)
                report_mismatch("status", 64'(got.status), 64'(w.status));
            if (got.timer_id !== w.timer_id)
                report_mismatch("timer_id", 64'(got.timer_id), 64'(w.timer_id));
            if (got.kind !== w.kind)
                report_mismatch("expired_kind", 64'(got.kind), 64'(w.kind));
            if (got.owner !== w.owner)
                report_mismatch("expired_owner", 64'(got.owner), 64'(w.owner));
            if (got.context_tag !== w.context_tag)
                report_mismatch("expired_context", 64'(got.context_tag),
                                64'(w.context_tag));
            if (got.last !== w.last)
                report_mismatch("last", 64'(got.last), 64'(w.last));
            if (got.pending !== w.pending)
                report_mismatch("pending_timers", 64'(got.pending), 64'(w.pending));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    wheel_scoreboard sb;
    int  idle_pct;
    int  stall_pct;
    int  hold_cycles;
    int  quiet_cycles;

    timer_wheel_expiry_core uut (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 0;
        else if (hold_cycles > 0)
        begin
            m_tready    <= 0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Check each result transaction
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.result_type = m_tuser[0];
            got.status      = m_tdata[1:0];
            got.timer_id    = m_tdata[33:2];
            got.kind        = m_tdata[34];
            got.owner       = m_tdata[50:35];
            got.context_tag = m_tdata[66:51];
            got.last        = m_tlast;
            got.pending     = m_tdata[72:67];
            sb.check(got);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL timer_wheel_expiry_core");
            $finish;
        end
    end

    task send_item(logic op, logic knd, logic [63:0] dl, logic [15:0] own,
                   logic [15:0] cx, logic [2:0] cpu, logic [63:0] now);
        // Hold off the sender for a random gap
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= {knd, op};
        s_tdata  <= {5'd0, now, cpu, cx, own, dl};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(op, knd, dl, own, cx, cpu, now);
    endtask

    task send_arm(logic knd, logic [63:0] dl, logic [15:0] own, logic [15:0] cx);
        send_item(OP_ARM, knd, dl, own, cx, 3'($urandom), {$urandom, $urandom});
    endtask

    task send_tick(logic [2:0] cpu, logic [63:0] now);
        send_item(OP_TICK, 1'($urandom), {$urandom, $urandom}, 16'($urandom),
                  16'($urandom), cpu, now);
    endtask

    // Pause the sender until every expected result is back
    task drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // One random transaction, mostly well formed
    task random_item();
        int          pick;
        logic [63:0] t;
        pick = $urandom_range(99);
        t = sb.cur_time;
        if (pick < 45)
        begin
            if ($urandom_range(1))
                send_arm(KIND_CALLBACK, t + 64'($urandom_range(1, 150)), 16'($urandom),
                         16'($urandom));
            else
                send_arm(KIND_SLEEP, t + 64'($urandom_range(1, 150)),
                         16'($urandom_range(1, 65535)), 16'($urandom));
        end
        else if (pick < 82)
            send_tick(3'($urandom), t + 64'($urandom_range(0, 3)));
        else if (pick < 88)
            send_tick(3'($urandom), 64'($urandom_range(0, 1000)));
        else if (pick < 94)
            send_arm(1'($urandom), {$urandom, $urandom}, 16'($urandom), 16'($urandom));
        else
            send_tick(3'($urandom), {$urandom, $urandom});
    endtask

    initial
    begin
        logic [63:0] t;
        sb = new();
        rst_n        = 0;
        s_tvalid     = 0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_cycles  = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: rejections, owner-less callback, unregistered cpu
        write_cfg(CFG_CPU_COUNT, 8'd0);
        send_arm(KIND_SLEEP, 64'd10, 16'd0, 16'hFFFF);
        send_arm(KIND_CALLBACK, 64'd5, 16'd0, 16'hFFFF);
        send_arm(KIND_SLEEP, 64'd0, 16'hFFFF, 16'h0);
        send_arm(KIND_SLEEP, 64'd69, 16'h1234, 16'h5678);
        send_tick(3'd7, 64'd5);
        send_tick(3'd0, 64'd6);
        send_tick(3'd0, 64'd69);
        // Fill the pool in one slot, overflow it, then expire all at once
        t = sb.cur_time + 64;
        for (int i = 0; i <= POOL; i++)
            send_arm(i[0], t, 16'($urandom_range(1, 65535)), 16'($urandom));
        send_tick(3'd1, t);
        // Largest deadline and time, then pull time back
        send_arm(KIND_SLEEP, '1, 16'hFFFF, 16'hFFFF);
        send_tick(3'd7, '1);
        send_tick(3'd0, 64'd0);
        drain();

        // Disabled block rejects arms and ignores ticks
        write_cfg(CFG_ENABLED, 8'd0);
        write_cfg(CFG_CPU_COUNT, 8'd15);
        send_arm(KIND_CALLBACK, 64'd100, 16'd1, 16'd2);
        send_tick(3'd0, 64'd50);
        drain();
        write_cfg(CFG_ENABLED, 8'd1);
        write_cfg(CFG_CPU_COUNT, 8'd8);

        // Random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 70 : 20) : 0;
            stall_pct = (ph == 2) ? 70 : ((ph == 3) ? 20 : 0);
            if (ph == 1) hold_cycles = 600;
            for (int n = 0; n < 20; n++) random_item();
            drain();
            write_cfg(CFG_CPU_COUNT, 8'($urandom_range(1, 8)));
        end
        write_cfg(CFG_ENABLED, 8'd1);

        drain();
        if (sb.errors == 0)
            $display("PASS timer_wheel_expiry_core");
        else
            $display("FAIL timer_wheel_expiry_core");
        $finish;
    end

endmodule
